[rtl/lsa_pkg.sv]
`timescale 1ns / 1ps

package lsa_pkg;

   localparam int LEVEL_W    = 12;
   localparam int TIME_W     = 32;
   localparam int INTERVAL_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_RAW      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_START = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_LIMIT = 2'd2;

   localparam logic [INTERVAL_W-1:0] INTERVAL_START_RST = 16'd1;
   localparam logic [INTERVAL_W-1:0] INTERVAL_LIMIT_RST = 16'd60;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMMIT,
      ST_SWEEP,
      ST_DRAIN,
      ST_DINIT,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic commit;
      logic sweep;
      logic div_init;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic fire;
      logic sweep_last;
      logic div_last;
   } sts_type;

endpackage

[rtl/lsa_ram.sv]
`timescale 1ns / 1ps

module lsa_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lsa_ctrl.sv]
`timescale 1ns / 1ps

module lsa_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   input  lsa_pkg::sts_type sts,
   output lsa_pkg::cmd_type cmd
);

   lsa_pkg::state_type state_ff, state_in;
   logic               out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lsa_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         lsa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = lsa_pkg::ST_COMMIT;
            end
         end
         lsa_pkg::ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = sts.fire ? lsa_pkg::ST_SWEEP : lsa_pkg::ST_DONE;
         end
         lsa_pkg::ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) begin
               state_in = lsa_pkg::ST_DRAIN;
            end
         end
         lsa_pkg::ST_DRAIN: begin
            state_in = lsa_pkg::ST_DINIT;
         end
         lsa_pkg::ST_DINIT: begin
            cmd.div_init = 1'b1;
            state_in     = lsa_pkg::ST_DIV;
         end
         lsa_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = lsa_pkg::ST_DONE;
            end
         end
         lsa_pkg::ST_DONE: begin
            if (!out_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = lsa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lsa_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;

endmodule

[rtl/lsa_dp.sv]
`timescale 1ns / 1ps

module lsa_dp #(
   parameter int SAMPLE_DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  lsa_pkg::cmd_type                 cmd,
   output lsa_pkg::sts_type                 sts,
   input  logic                             csr_we,
   input  logic [lsa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lsa_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [lsa_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic [lsa_pkg::LEVEL_W-1:0]      rsp_level,
   output logic                             rsp_updated
);

   localparam int AW    = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
   localparam int CW    = $clog2(SAMPLE_DEPTH + 1);
   localparam int SUM_W = lsa_pkg::LEVEL_W + CW;
   localparam int DW    = $clog2(SUM_W);

   logic [lsa_pkg::LEVEL_W-1:0]    empty_raw_ff;
   logic [lsa_pkg::INTERVAL_W-1:0] limit_ff;
   logic [lsa_pkg::INTERVAL_W-1:0] cur_int_ff, cur_int_in, cur_int_next;
   logic [lsa_pkg::TIME_W:0]       next_time_ff;
   logic                           has_result_ff;
   logic [lsa_pkg::LEVEL_W-1:0]    pub_ff;
   logic                           fire_ff;
   logic [AW-1:0]                  slot_ff;
   logic [CW-1:0]                  fill_ff;
   logic [lsa_pkg::LEVEL_W-1:0]    raw_ff;
   logic [lsa_pkg::TIME_W-1:0]     now_ff;
   logic [AW-1:0]                  rd_addr_ff;
   logic                           rdv_ff;
   logic [SUM_W-1:0]               sum_ff;
   logic [SUM_W-1:0]               quo_ff;
   logic [CW-1:0]                  rem_ff;
   logic [DW-1:0]                  dcnt_ff;
   logic [lsa_pkg::LEVEL_W-1:0]    rsp_level_ff;
   logic                           rsp_updated_ff;

   logic [lsa_pkg::LEVEL_W-1:0]    lvl;
   logic [lsa_pkg::LEVEL_W-1:0]    rd_data;
   logic                           fire;
   logic [CW:0]                    trial;
   logic                           ge;
   logic [lsa_pkg::LEVEL_W-1:0]    new_level;

   assign lvl = (raw_ff >= empty_raw_ff) ? (raw_ff - empty_raw_ff) : (empty_raw_ff - raw_ff);
   assign fire = !has_result_ff || (next_time_ff < {1'b0, now_ff});
   assign cur_int_next = (cur_int_ff < limit_ff) ? (cur_int_ff + 1'b1) : cur_int_ff;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign ge    = trial >= {1'b0, fill_ff};

   assign sts.fire       = fire;
   assign sts.sweep_last = ((CW+1)'(rd_addr_ff) + (CW+1)'(1)) == (CW+1)'(fill_ff);
   assign sts.div_last   = (dcnt_ff == '0);

   assign new_level = fire_ff ? quo_ff[lsa_pkg::LEVEL_W-1:0] : pub_ff;

   lsa_ram #(
      .WIDTH (lsa_pkg::LEVEL_W),
      .DEPTH (SAMPLE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (slot_ff),
      .wr_data (lvl),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      cur_int_in = cur_int_ff;
      if (csr_we && (csr_index == lsa_pkg::CSR_INTERVAL_START)) begin
         cur_int_in = csr_wdata;
      end else if (cmd.commit && fire) begin
         cur_int_in = cur_int_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_raw_ff  <= '0;
         limit_ff      <= lsa_pkg::INTERVAL_LIMIT_RST;
         cur_int_ff    <= lsa_pkg::INTERVAL_START_RST;
         next_time_ff  <= '0;
         has_result_ff <= 1'b0;
         pub_ff        <= '0;
         fire_ff       <= 1'b0;
         slot_ff       <= '0;
         fill_ff       <= '0;
         rdv_ff        <= 1'b0;
      end else begin
         cur_int_ff <= cur_int_in;
         if (csr_we) begin
            case (csr_index)
               lsa_pkg::CSR_EMPTY_RAW: begin
                  empty_raw_ff <= csr_wdata[lsa_pkg::LEVEL_W-1:0];
               end
               lsa_pkg::CSR_INTERVAL_LIMIT: begin
                  limit_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
         rdv_ff <= cmd.sweep;
         if (cmd.commit) begin
            fire_ff <= fire;
            slot_ff <= (slot_ff == AW'(SAMPLE_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
            if (fill_ff != CW'(SAMPLE_DEPTH)) begin
               fill_ff <= fill_ff + 1'b1;
            end
            if (fire) begin
               next_time_ff  <= (lsa_pkg::TIME_W+1)'(now_ff)
                                + (lsa_pkg::TIME_W+1)'(cur_int_next);
               has_result_ff <= 1'b1;
            end
         end
         if (cmd.out_load) begin
            pub_ff <= new_level;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         raw_ff <= req_tdata[lsa_pkg::LEVEL_W-1:0];
         now_ff <= req_tdata[lsa_pkg::LEVEL_W +: lsa_pkg::TIME_W];
      end
      if (cmd.commit) begin
         rd_addr_ff <= '0;
         sum_ff     <= '0;
      end else begin
         if (cmd.sweep) begin
            rd_addr_ff <= rd_addr_ff + 1'b1;
         end
         if (rdv_ff) begin
            sum_ff <= sum_ff + SUM_W'(rd_data);
         end
      end
      if (cmd.div_init) begin
         quo_ff  <= sum_ff;
         rem_ff  <= '0;
         dcnt_ff <= DW'(SUM_W - 1);
      end else if (cmd.div_step) begin
         quo_ff  <= {quo_ff[SUM_W-2:0], ge};
         rem_ff  <= ge ? CW'(trial - {1'b0, fill_ff}) : CW'(trial);
         dcnt_ff <= dcnt_ff - 1'b1;
      end
      if (cmd.out_load) begin
         rsp_level_ff   <= new_level;
         rsp_updated_ff <= fire_ff;
      end
   end

   assign rsp_level   = rsp_level_ff;
   assign rsp_updated = rsp_updated_ff;

endmodule

[rtl/level_sensor_averager_core.sv]
`timescale 1ns / 1ps
// When no average is due, an accepted item goes from COMMIT straight to DONE and its result
// is loaded; when one is due, the ring read sweep over the fill samples held (SWEEP, DRAIN)
// and the bit-serial divider (DINIT, DIV; SUM_W = 12 + clog2(depth+1) quotient bits) run first.
// One item in flight at a time: a new request is taken only after the last result is loaded.
// Reset (synchronous, active high) clears control, schedule, ring fill and config.
module level_sensor_averager_core #(
   parameter int SAMPLE_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [lsa_pkg::REQ_DATA_W-1:0] req_tdata,  // raw_level[11:0], now_seconds[43:12]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [lsa_pkg::RSP_DATA_W-1:0] rsp_tdata,  // level[11:0]
   output logic                           rsp_tuser,  // updated
   input  logic                           csr_we,
   input  logic [lsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lsa_pkg::CSR_DATA_W-1:0] csr_wdata
);

   lsa_pkg::cmd_type            cmd;
   lsa_pkg::sts_type            sts;
   logic [lsa_pkg::LEVEL_W-1:0] rsp_level;

   lsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lsa_dp #(
      .SAMPLE_DEPTH (SAMPLE_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tdata   (req_tdata),
      .rsp_level   (rsp_level),
      .rsp_updated (rsp_tuser)
   );

   assign rsp_tdata = {{(lsa_pkg::RSP_DATA_W - lsa_pkg::LEVEL_W){1'b0}}, rsp_level};

endmodule

[rtl/lsa_checker.sv]
`timescale 1ns / 1ps

module lsa_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [lsa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // one item at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("accepted a second item while busy");

   // reset leaves the block idle with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

   // no result can appear the cycle right after an accept
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared too early");

endmodule

bind level_sensor_averager_core lsa_checker u_lsa_checker (.*);
